// ----- rtl/b64d_pkg.sv -----
// Shared types and constants for the base64 decoder.
// Used by the step logic and the top level.
package b64d_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [6:0] SEXTET_INVALID = 7'd64;
    localparam logic [7:0] PAD_CHAR_RESET = 8'd61;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } b64d_op_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_BAD_PAD  = 2'd3
    } b64d_status_t;

    // Quad state carried between characters of one text.
    typedef struct packed
    {
        logic [17:0]  sextets;
        logic [1:0]   pos;
        logic         third_pad;
        b64d_status_t err;
    } b64d_state_t;

    typedef struct packed
    {
        logic [7:0]   out_byte;
        logic         byte_valid;
        logic         final_res;
        b64d_status_t status;
    } b64d_res_t;

endpackage

// ----- rtl/b64d_if.sv -----
// Valid/ready channel interfaces for the base64 decoder.
// Depends on nothing; payload fields follow the decoder's item layouts.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [6:0] entry_value;
    logic       end_of_text;

    modport source (output valid, opcode, char_code, entry_value, end_of_text, input ready);
    modport sink (input valid, opcode, char_code, entry_value, end_of_text, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       final_res;
    logic [1:0] status;

    modport source (output valid, out_byte, byte_valid, final_res, status, input ready);
    modport sink (input valid, out_byte, byte_valid, final_res, status, output ready);
endinterface

// ----- rtl/b64d_step.sv -----
// Combinational decode of one character against the current quad state.
// Depends on b64d_pkg for the state, result and status types.
module b64d_step
(
    input  b64d_pkg::b64d_state_t state,
    input  logic [7:0]            char_code,
    input  logic [6:0]            entry,
    input  logic                  end_of_text,
    input  logic [7:0]            pad_char,
    output b64d_pkg::b64d_state_t state_next,
    output logic [1:0]            res_cnt,
    output b64d_pkg::b64d_res_t   res [b64d_pkg::MAX_RESULTS]
);

    logic                  is_valid;
    logic                  padded;
    logic                  is_pad;
    logic [5:0]            sx;
    logic [23:0]           shifted;
    logic [23:0]           word;
    logic [1:0]            nbytes;
    logic                  normal;
    logic                  third_n;
    logic                  len_bad;
    b64d_pkg::b64d_status_t err;
    b64d_pkg::b64d_status_t st_fin;

    assign is_valid = ~entry[6];
    assign padded   = (pad_char != 8'd0);
    assign is_pad   = padded && (char_code == pad_char) && !is_valid;
    assign sx       = is_valid ? entry[5:0] : 6'd0;
    assign shifted  = {state.sextets, sx};
    assign len_bad  = padded ? (state.pos != 2'd3) : (state.pos == 2'd0);

    always_comb
    begin
        err     = state.err;
        normal  = 1'b0;
        third_n = state.third_pad;
        word    = 24'd0;
        nbytes  = 2'd0;
        if (state.err == b64d_pkg::ST_OK)
        begin
            priority if (!is_valid && !is_pad)
            begin
                err = b64d_pkg::ST_BAD_CHAR;
            end
            else if (is_pad && !state.pos[1])
            begin
                err = b64d_pkg::ST_BAD_PAD;
            end
            else if (is_valid && state.third_pad)
            begin
                err = b64d_pkg::ST_BAD_PAD;
            end
            else if (is_pad && (state.pos == 2'd3) && !end_of_text)
            begin
                err = b64d_pkg::ST_BAD_PAD;
            end
            else
            begin
                normal = 1'b1;
                if (is_pad && (state.pos == 2'd2))
                begin
                    third_n = 1'b1;
                end
                if (state.pos == 2'd3)
                begin
                    word = shifted;
                    if (is_pad)
                    begin
                        nbytes = state.third_pad ? 2'd1 : 2'd2;
                    end
                    else
                    begin
                        nbytes = 2'd3;
                    end
                end
                else if (end_of_text && !padded)
                begin
                    // A short unpadded tail is left-aligned into the 24-bit word.
                    if (state.pos == 2'd1)
                    begin
                        word   = {shifted[11:0], 12'd0};
                        nbytes = 2'd1;
                    end
                    else if (state.pos == 2'd2)
                    begin
                        word   = {shifted[17:0], 6'd0};
                        nbytes = 2'd2;
                    end
                end
            end
        end
    end

    assign st_fin = len_bad ? b64d_pkg::ST_BAD_LEN : err;

    always_comb
    begin
        state_next = state;
        res_cnt    = 2'd0;
        for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
        begin
            res[2'(k)] = '0;
        end
        if (end_of_text)
        begin
            state_next = '0;
            if ((st_fin != b64d_pkg::ST_OK) || (nbytes == 2'd0))
            begin
                res_cnt          = 2'd1;
                res[0].final_res = 1'b1;
                res[0].status    = st_fin;
            end
            else
            begin
                res_cnt = nbytes;
                for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
                begin
                    res[2'(k)].out_byte   = word[23 - 8 * k -: 8];
                    res[2'(k)].byte_valid = 1'b1;
                    res[2'(k)].final_res  = ((2'(k) + 2'd1) == nbytes);
                end
            end
        end
        else
        begin
            state_next.err = err;
            state_next.pos = state.pos + 2'd1;
            if (state.pos == 2'd3)
            begin
                state_next.sextets   = 18'd0;
                state_next.third_pad = 1'b0;
            end
            else
            begin
                state_next.sextets   = normal ? shifted[17:0] : state.sextets;
                state_next.third_pad = third_n;
            end
            res_cnt = (err != b64d_pkg::ST_OK) ? 2'd0 : nbytes;
            for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
            begin
                res[2'(k)].out_byte   = word[23 - 8 * k -: 8];
                res[2'(k)].byte_valid = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/base64_decoder_checked.sv -----
// Top level of the streaming base64 decoder: alphabet table, stage register,
// result group buffer. Depends on b64d_pkg, b64d_if and b64d_step.
//
//  Port     | Dir | Moves
//  item     | in  | one request: table load or one character (valid/ready)
//  result   | out | one decoded byte or the final status (valid/ready)
//  cfg_we   | in  | write enable of the padding character register
//
// One request is taken per cycle unless the stage register is held.
// A character yields up to three results, sent one per cycle from the group buffer
// unless the output stalls; a request with results that follows a three-byte group
// too closely waits in the stage register until the group is down to its last byte.
// The alphabet table is a 256-entry memory with one written flag per entry;
// reset clears the flags at once, so there is no clearing pass.
// A stalled output holds the group buffer and then the stage register.
module base64_decoder_checked
(
    input  logic             clk,
    input  logic             rst_n,
    b64d_in_if.sink          item,
    b64d_out_if.source       result,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata
);

    logic [7:0]             pad_char_reg;

    logic [6:0]             table_mem [b64d_pkg::TABLE_DEPTH];
    logic [b64d_pkg::TABLE_DEPTH-1:0] written_reg;
    logic [6:0]             rd_data_reg;
    logic                   rd_written_reg;

    logic                   s1_valid_reg;
    logic [7:0]             s1_char_reg;
    logic                   s1_eot_reg;
    logic [6:0]             s1_entry;

    b64d_pkg::b64d_state_t  state_reg;
    b64d_pkg::b64d_state_t  state_next;
    logic [1:0]             step_cnt;
    b64d_pkg::b64d_res_t    step_res [b64d_pkg::MAX_RESULTS];

    logic [1:0]             rem_reg;
    b64d_pkg::b64d_res_t    grp_res_reg [b64d_pkg::MAX_RESULTS];

    logic                   in_acc;
    logic                   dec_acc;
    logic                   load_we;
    logic                   take;
    logic                   grp_free;
    logic                   s1_adv;
    logic                   grp_load;

    assign in_acc   = item.valid && item.ready;
    assign dec_acc  = in_acc && (item.opcode == b64d_pkg::OP_DECODE);
    assign load_we  = in_acc && (item.opcode == b64d_pkg::OP_LOAD);
    assign take     = result.valid && result.ready;
    assign grp_free = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && result.ready);
    assign s1_adv   = s1_valid_reg && ((step_cnt == 2'd0) || grp_free);
    assign grp_load = s1_adv && (step_cnt != 2'd0);
    assign item.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_char_reg <= b64d_pkg::PAD_CHAR_RESET;
        end
        else if (cfg_we)
        begin
            pad_char_reg <= cfg_wdata;
        end
    end

    // Loads are written when taken, so any later character reads the new entry.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            table_mem[item.char_code] <= item.entry_value;
        end
        if (dec_acc)
        begin
            rd_data_reg <= table_mem[item.char_code];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (load_we)
            begin
                written_reg[item.char_code] <= 1'b1;
            end
            if (dec_acc)
            begin
                rd_written_reg <= written_reg[item.char_code];
            end
        end
    end

    assign s1_entry = rd_written_reg ? rd_data_reg : b64d_pkg::SEXTET_INVALID;

    always_ff @(posedge clk)
    begin
        if (dec_acc)
        begin
            s1_char_reg <= item.char_code;
            s1_eot_reg  <= item.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
            rem_reg      <= 2'd0;
        end
        else
        begin
            if (dec_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
            if (grp_load)
            begin
                rem_reg <= step_cnt;
            end
            else if (take)
            begin
                rem_reg <= rem_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            grp_res_reg <= step_res;
        end
        else if (take)
        begin
            grp_res_reg[0] <= grp_res_reg[1];
            grp_res_reg[1] <= grp_res_reg[2];
        end
    end

    b64d_step u_step
    (
        .state       (state_reg),
        .char_code   (s1_char_reg),
        .entry       (s1_entry),
        .end_of_text (s1_eot_reg),
        .pad_char    (pad_char_reg),
        .state_next  (state_next),
        .res_cnt     (step_cnt),
        .res         (step_res)
    );

    assign result.valid      = (rem_reg != 2'd0);
    assign result.out_byte   = grp_res_reg[0].out_byte;
    assign result.byte_valid = grp_res_reg[0].byte_valid;
    assign result.final_res  = grp_res_reg[0].final_res;
    assign result.status     = grp_res_reg[0].status;

`ifndef SYNTHESIS
    a_group_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        grp_load |-> (rem_reg == 2'd0) || ((rem_reg == 2'd1) && take))
        else $error("result group reloaded while results were still pending");

    a_eot_clears_quad: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_eot_reg) |=>
            (state_reg.pos == 2'd0) && (state_reg.err == b64d_pkg::ST_OK))
        else $error("quad state not cleared after the end of a text");

    a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.final_res) |->
            (result.status == b64d_pkg::ST_OK) && result.byte_valid)
        else $error("non-final result carries a status or no byte");

    a_status_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.byte_valid) |-> result.final_res && (result.out_byte == 8'd0))
        else $error("status result is not final or carries a byte");
`endif

endmodule
